// ===== rtl/mrt_pkg.sv =====
// Shared types and constants for the top-k expert router.
// No dependencies; every other file in rtl/ except mrt_div uses this package.
package mrt_pkg;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;
	localparam int ScoreW   = 16;
	localparam int IdxOutW  = 6;
	localparam int WeightW  = 24;
	localparam int ValW     = 15;
	localparam int ScaleW   = 16;
	localparam int TopkW    = 4;
	localparam int NumExpW  = 7;
	localparam int ProdW    = ValW + ScaleW;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TOP_K       = 2'd0,
		REG_NUM_EXPERTS = 2'd1,
		REG_NORMALIZE   = 2'd2,
		REG_SCALE       = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCAN,
		B_PICK,
		B_MUL,
		B_WGT,
		B_DIV,
		B_EMIT
	} back_state_t;

	// row descriptor handed from front to back; sized for the largest build
	typedef struct packed {
		logic [8:0]        experts;
		logic [4:0]        picks;
		logic              norm;
		logic [ScaleW-1:0] scale;
	} job_t;

	typedef struct packed {
		logic idle;
		logic done;
	} back_stat_t;

endpackage

// ===== rtl/mrt_ifs.sv =====
// Stream interfaces for score items in and selection items out.
// Depends on mrt_pkg for field widths.
interface mrt_score_if;
	logic                              valid;
	logic                              ready;
	logic signed [mrt_pkg::ScoreW-1:0] score;
	modport source(output valid, output score, input ready);
	modport sink(input valid, input score, output ready);
endinterface

interface mrt_sel_if;
	logic                         valid;
	logic                         ready;
	logic [mrt_pkg::IdxOutW-1:0]  expert_index;
	logic [mrt_pkg::WeightW-1:0]  weight;
	logic                         last_of_row;
	modport source(output valid, output expert_index, output weight, output last_of_row,
		input ready);
	modport sink(input valid, input expert_index, input weight, input last_of_row,
		output ready);
endinterface

// ===== rtl/mrt_front.sv =====
// Front end: takes scores, writes them to the back's row store, detects row end.
// Depends on mrt_pkg and mrt_score_if.
module mrt_front #(
	parameter int MAX_EXPERTS = 64,
	parameter int MAX_TOPK    = 8,
	localparam int IW = $clog2(MAX_EXPERTS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mrt_score_if.sink                         in_ch,
	input  logic [mrt_pkg::TopkW-1:0]         top_k,
	input  logic [mrt_pkg::NumExpW-1:0]       num_experts,
	input  logic                              normalize_enable,
	input  logic [mrt_pkg::ScaleW-1:0]        scaling_factor,
	output mrt_pkg::job_t                     job,
	output logic                              job_vld,
	input  logic                              job_pop,
	input  logic                              row_done,
	output logic                              wr_en,
	output logic [IW-1:0]                     wr_addr,
	output logic signed [mrt_pkg::ScoreW-1:0] wr_data
);
	import mrt_pkg::*;

	localparam int EW = $clog2(MAX_EXPERTS + 1);

	logic [EW-1:0] count_q;
	logic          busy_q;
	logic          job_vld_q;
	job_t          job_q;
	logic [EW-1:0] e_eff;
	logic [4:0]    k_eff;
	logic          acc;
	logic          row_end;

	always_comb begin
		int n;
		int kk;
		n = int'(num_experts);
		if (n == 0) n = 1;
		if (n > MAX_EXPERTS) n = MAX_EXPERTS;
		kk = int'(top_k);
		if (kk > n) kk = n;
		if (kk > MAX_TOPK) kk = MAX_TOPK;
		e_eff = EW'(n);
		k_eff = 5'(kk);
	end

	assign in_ch.ready = !busy_q;
	assign acc         = in_ch.valid && !busy_q;
	assign row_end     = ({1'b0, count_q} + (EW+1)'(1)) >= {1'b0, e_eff};

	assign wr_en   = acc && (int'(count_q) < MAX_EXPERTS);
	assign wr_addr = count_q[IW-1:0];
	assign wr_data = in_ch.score;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			busy_q    <= 1'b0;
			job_vld_q <= 1'b0;
		end else begin
			if (job_pop) job_vld_q <= 1'b0;
			if (row_done) busy_q <= 1'b0;
			if (acc) begin
				if (row_end) begin
					count_q   <= '0;
					busy_q    <= 1'b1;
					job_vld_q <= 1'b1;
				end else begin
					count_q <= count_q + EW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && row_end) begin
			job_q.experts <= 9'(e_eff);
			job_q.picks   <= k_eff;
			job_q.norm    <= normalize_enable;
			job_q.scale   <= scaling_factor;
		end
	end

	assign job     = job_q;
	assign job_vld = job_vld_q;

endmodule

// ===== rtl/mrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module mrt_div #(
	parameter int NW = 31,
	parameter int DW = 19
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = (NW > 1) ? $clog2(NW) : 1;

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) run_q <= 1'b0;
				else cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/mrt_back.sv =====
// Back end: row store, repeated max scans, weight computation, output register.
// Depends on mrt_pkg, mrt_sel_if and mrt_div.
module mrt_back #(
	parameter int MAX_EXPERTS = 64,
	parameter int MAX_TOPK    = 8,
	localparam int IW = $clog2(MAX_EXPERTS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [IW-1:0]                     wr_addr,
	input  logic signed [mrt_pkg::ScoreW-1:0] wr_data,
	input  mrt_pkg::job_t                     job,
	input  logic                              job_vld,
	output logic                              job_pop,
	output mrt_pkg::back_stat_t               stat,
	mrt_sel_if.source                         out_ch
);
	import mrt_pkg::*;

	localparam int EW  = $clog2(MAX_EXPERTS + 1);
	localparam int KW  = $clog2(MAX_TOPK + 1);
	localparam int KIW = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;
	localparam int SW  = ValW + $clog2(MAX_TOPK + 1);

	logic signed [ScoreW-1:0] mem [MAX_EXPERTS];

	back_state_t state_q, state_d;

	logic [IW-1:0]            j_q;
	logic                     rd_vld_s1;
	logic [IW-1:0]            rd_idx_s1;
	logic signed [ScoreW-1:0] rd_data_s1;
	logic                     have_q;
	logic signed [ScoreW-1:0] best_v_q;
	logic [IW-1:0]            best_j_q;
	logic [MAX_EXPERTS-1:0]   used_q;
	logic [KW-1:0]            k_q;
	logic [EW-1:0]            e_q;
	logic [KW-1:0]            kcnt_q;
	logic                     norm_q;
	logic [ScaleW-1:0]        scale_q;
	logic [SW-1:0]            sum_q;
	logic [ProdW-1:0]         prod_q;
	logic [WeightW-1:0]       w_q;
	logic [IW-1:0]            chosen_idx_q [MAX_TOPK];
	logic [ValW-1:0]          chosen_val_q [MAX_TOPK];
	logic                     out_vld_q;
	logic [IdxOutW-1:0]       out_idx_q;
	logic [WeightW-1:0]       out_w_q;
	logic                     out_last_q;

	logic                     cand;
	logic signed [ScoreW-1:0] nb_v;
	logic [IW-1:0]            nb_j;
	logic [ValW-1:0]          nb_clamp;
	logic                     scan_last;
	logic                     last_pick;
	logic                     out_free;
	logic                     use_div;
	logic                     div_start;
	logic                     div_done;
	logic [ProdW-1:0]         div_quo;
	logic [KIW-1:0]           kidx;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[j_q];
		rd_idx_s1  <= j_q;
	end

	// running maximum, ties keep the lower index
	assign cand     = rd_vld_s1 && !used_q[rd_idx_s1] && (!have_q || rd_data_s1 > best_v_q);
	assign nb_v     = cand ? rd_data_s1 : best_v_q;
	assign nb_j     = cand ? rd_idx_s1 : best_j_q;
	assign nb_clamp = (nb_v > 0) ? nb_v[ValW-1:0] : '0;

	assign kidx      = k_q[KIW-1:0];
	assign scan_last = (EW'(j_q) + EW'(1)) == e_q;
	assign last_pick = (k_q + KW'(1)) == kcnt_q;
	assign out_free  = !out_vld_q || out_ch.ready;
	assign use_div   = norm_q && (sum_q != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (job_vld && job.picks != '0) state_d = B_SCAN;
			B_SCAN: if (scan_last) state_d = B_PICK;
			B_PICK: state_d = last_pick ? B_MUL : B_SCAN;
			B_MUL:  state_d = B_WGT;
			B_WGT:  state_d = use_div ? B_DIV : B_EMIT;
			B_DIV:  if (div_done) state_d = B_EMIT;
			B_EMIT: if (out_free) state_d = last_pick ? B_IDLE : B_MUL;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		job_pop   = 1'b0;
		stat.idle = 1'b0;
		stat.done = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				stat.idle = 1'b1;
				job_pop   = job_vld;
				stat.done = job_vld && (job.picks == '0);
			end
			B_WGT:  div_start = use_div;
			B_EMIT: stat.done = out_free && last_pick;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_vld_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == B_SCAN);
			if (state_q == B_EMIT && out_free) out_vld_q <= 1'b1;
			else if (out_ch.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				j_q     <= '0;
				have_q  <= 1'b0;
				used_q  <= '0;
				k_q     <= '0;
				sum_q   <= '0;
				e_q     <= job.experts[EW-1:0];
				kcnt_q  <= job.picks[KW-1:0];
				norm_q  <= job.norm && (job.picks > 5'd1);
				scale_q <= job.scale;
			end
			B_SCAN: begin
				j_q      <= j_q + IW'(1);
				have_q   <= have_q || cand;
				best_v_q <= nb_v;
				best_j_q <= nb_j;
			end
			B_PICK: begin
				chosen_idx_q[kidx] <= nb_j;
				chosen_val_q[kidx] <= nb_clamp;
				used_q[nb_j]       <= 1'b1;
				sum_q              <= sum_q + SW'(nb_clamp);
				have_q             <= 1'b0;
				j_q                <= '0;
				k_q                <= last_pick ? '0 : k_q + KW'(1);
			end
			B_MUL: prod_q <= ProdW'(chosen_val_q[kidx]) * ProdW'(scale_q);
			B_WGT: begin
				if (norm_q) w_q <= '0;
				else w_q <= WeightW'(prod_q >> 8);
			end
			B_DIV: if (div_done) w_q <= div_quo[WeightW-1:0];
			B_EMIT: begin
				if (out_free) begin
					out_idx_q  <= IdxOutW'(chosen_idx_q[kidx]);
					out_w_q    <= w_q;
					out_last_q <= last_pick;
					k_q        <= k_q + KW'(1);
				end
			end
			default: ;
		endcase
	end

	mrt_div #(.NW(ProdW), .DW(SW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (sum_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign out_ch.valid        = out_vld_q;
	assign out_ch.expert_index = out_idx_q;
	assign out_ch.weight       = out_w_q;
	assign out_ch.last_of_row  = out_last_q;

endmodule

// ===== rtl/moe_router_topk_weights.sv =====
// Top-k expert gating: one score per input item, up to MAX_TOPK selections per row.
// Flow: a row of E scores is taken one score per cycle; input then stalls while the back
// end runs K scans over the row store (one write and one read port), and for each pick
// one multiply, then a divide (normalized, K>1, nonzero sum), a zero weight (normalized,
// zero sum) or a shift, and an output step. The next row is accepted once the last pick
// has entered the output register. Depends on mrt_pkg, mrt_ifs, mrt_front, mrt_back.
module moe_router_topk_weights #(
	parameter int MAX_EXPERTS = 64,
	parameter int MAX_TOPK    = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mrt_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [mrt_pkg::CfgDataW-1:0]  cfg_wdata,
	mrt_score_if.sink                     in_ch,
	mrt_sel_if.source                     out_ch
);
	import mrt_pkg::*;

	localparam int IW = $clog2(MAX_EXPERTS);

	logic [TopkW-1:0]   top_k_q;
	logic [NumExpW-1:0] num_experts_q;
	logic               normalize_q;
	logic [ScaleW-1:0]  scale_q;

	job_t               job;
	logic               job_vld;
	logic               job_pop;
	back_stat_t         stat;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic signed [ScoreW-1:0] wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q       <= TopkW'(2);
			num_experts_q <= NumExpW'(64);
			normalize_q   <= 1'b1;
			scale_q       <= ScaleW'(4096);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_TOP_K:       top_k_q       <= cfg_wdata[TopkW-1:0];
				REG_NUM_EXPERTS: num_experts_q <= cfg_wdata[NumExpW-1:0];
				REG_NORMALIZE:   normalize_q   <= cfg_wdata[0];
				REG_SCALE:       scale_q       <= cfg_wdata[ScaleW-1:0];
				default: ;
			endcase
		end
	end

	mrt_front #(.MAX_EXPERTS(MAX_EXPERTS), .MAX_TOPK(MAX_TOPK)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_ch            (in_ch),
		.top_k            (top_k_q),
		.num_experts      (num_experts_q),
		.normalize_enable (normalize_q),
		.scaling_factor   (scale_q),
		.job              (job),
		.job_vld          (job_vld),
		.job_pop          (job_pop),
		.row_done         (stat.done),
		.wr_en            (wr_en),
		.wr_addr          (wr_addr),
		.wr_data          (wr_data)
	);

	mrt_back #(.MAX_EXPERTS(MAX_EXPERTS), .MAX_TOPK(MAX_TOPK)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.job     (job),
		.job_vld (job_vld),
		.job_pop (job_pop),
		.stat    (stat),
		.out_ch  (out_ch)
	);

	// input is only open while the back end has no row
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> stat.idle) else $error("input open while back end busy");

	a_done_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> in_ch.ready) else $error("row finished but input stayed closed");

	a_job_closed: assert property (@(posedge clk) disable iff (!arst_n)
		job_vld |-> !in_ch.ready) else $error("row pending while input open");

endmodule
